// ===== src/lfusr_pkg.sv =====
// ----------------------------------------------------------------------------
// lfusr_pkg
// Shared types and constants of the lfu slot replacement unit.
// ----------------------------------------------------------------------------
package lfusr_pkg;

  localparam int unsigned CountW     = 16;
  localparam int unsigned StampW     = 32;
  localparam int unsigned IdW        = 7;
  localparam int unsigned SlotW      = 6;
  localparam int unsigned ResultCap  = 32;
  localparam int unsigned SlotsReset = 20;

  localparam logic [CountW-1:0] COUNT_MAX = '1;
  localparam logic [StampW-1:0] SEQ_MAX   = '1;
  localparam logic [SlotW-1:0]  OCC_MAX   = '1;

  typedef enum logic {
    CMD_RECOMMEND = 1'b0,
    CMD_LIST      = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_ACK   = 2'd0,
    KIND_ENTRY = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    OP_KEEP,
    OP_BUMP,
    OP_CLEAR,
    OP_INSERT
  } cell_op_t;

  typedef struct packed {
    logic              res;
    logic [CountW-1:0] cnt;
    logic [StampW-1:0] stamp;
  } entry_t;

  typedef struct packed {
    cell_op_t          op;
    logic [StampW-1:0] stamp;
  } cell_cmd_t;

  localparam cell_cmd_t CELL_CMD_KEEP = '{op: OP_KEEP, stamp: '0};

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PLACE,
    S_LIST,
    S_FLUSH
  } state_t;

endpackage

// ===== src/lfu_slot_replacement_unit.sv =====
// ----------------------------------------------------------------------------
// lfu_slot_replacement_unit
// LFU slot replacement with oldest-insertion tiebreak over a ring of id cells.
// ----------------------------------------------------------------------------
//  channel  ports                                   handshake
//  input    in_command, in_candidate_id             start & !busy
//  result   out_kind, out_listed_id, out_evicted,   out_strobe, one cycle
//           out_evicted_id, out_last
//  config   cfg_data                                cfg_valid & cfg_ready
//
//  the entries rotate through a ring of ID_COUNT cells, one hop a cycle
//  while a lap is running; the head cell is examined at each hop
//  recommend: one lap for a hit, two laps for an insert;
//  list: one lap, then S_FLUSH; an out-of-range id is acknowledged at once
//  reset clears the resident flag and count of all cells, no clearing pass
//  the receiver cannot stall; results leave from a single output register
// ----------------------------------------------------------------------------
module lfu_slot_replacement_unit #(
  parameter int unsigned ID_COUNT  = 128,
  parameter int unsigned MAX_SLOTS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_command,
  input  logic [6:0] in_candidate_id,
  output logic       out_strobe,
  output logic [1:0] out_kind,
  output logic [6:0] out_listed_id,
  output logic       out_evicted,
  output logic [6:0] out_evicted_id,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [5:0] cfg_data
);
  import lfusr_pkg::*;

  localparam int unsigned IW = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
  localparam int unsigned CW = (IW > IdW) ? IW : IdW;
  localparam logic [IW-1:0] IDX_LAST = IW'(ID_COUNT - 1);
  localparam logic [CW:0]   ID_LIMIT = (CW+1)'(ID_COUNT);
  localparam logic [6:0]    SLOT_CAP = 7'(MAX_SLOTS);
  localparam logic [5:0]    NCOL_CAP = 6'(ResultCap);

  entry_t    ring_q [ID_COUNT];
  entry_t    head;
  cell_cmd_t tail_cmd;
  logic      shift_en;

  state_t            state_r, state_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [IdW-1:0]    id_r, id_nxt;
  logic              hit_r, hit_nxt;
  logic              found_r, found_nxt;
  logic [IW-1:0]     best_id_r, best_id_nxt;
  logic [CountW-1:0] best_cnt_r, best_cnt_nxt;
  logic [StampW-1:0] best_stamp_r, best_stamp_nxt;
  logic [StampW-1:0] seq_r, seq_nxt;
  logic [SlotW-1:0]  occ_r, occ_nxt;
  logic [SlotW-1:0]  slots_r;
  logic              pend_r, pend_nxt;
  logic [IW-1:0]     pend_id_r, pend_id_nxt;
  logic [5:0]        ncol_r, ncol_nxt;

  logic           strobe_r, strobe_nxt;
  kind_t          kind_r, kind_nxt;
  logic [IdW-1:0] listed_r, listed_nxt;
  logic           ev_r, ev_nxt;
  logic [IdW-1:0] ev_id_r, ev_id_nxt;
  logic           last_r, last_nxt;

  logic [6:0] limit;
  logic       at_id;
  logic       at_best;
  logic       lap_end;
  logic       better;
  logic       evict;

  for (genvar g = 0; g < ID_COUNT; g++) begin : g_ring
    if (g == ID_COUNT - 1) begin : g_tail
      lfusr_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .shift_en(shift_en),
        .d       (ring_q[0]),
        .cmd     (tail_cmd),
        .q       (ring_q[g])
      );
    end else begin : g_body
      lfusr_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .shift_en(shift_en),
        .d       (ring_q[g+1]),
        .cmd     (CELL_CMD_KEEP),
        .q       (ring_q[g])
      );
    end
  end

  assign head = ring_q[0];

  always_comb begin
    if (slots_r == '0) begin
      limit = 7'd1;
    end else if (7'(slots_r) > SLOT_CAP) begin
      limit = SLOT_CAP;
    end else begin
      limit = 7'(slots_r);
    end
  end

  assign at_id   = (CW'(idx_r) == CW'(id_r));
  assign at_best = (idx_r == best_id_r);
  assign lap_end = (idx_r == IDX_LAST);
  assign better  = !found_r || (head.cnt < best_cnt_r) ||
                   ((head.cnt == best_cnt_r) && (head.stamp < best_stamp_r));
  assign evict   = (7'(occ_r) >= limit) && found_r;

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    id_nxt         = id_r;
    hit_nxt        = hit_r;
    found_nxt      = found_r;
    best_id_nxt    = best_id_r;
    best_cnt_nxt   = best_cnt_r;
    best_stamp_nxt = best_stamp_r;
    seq_nxt        = seq_r;
    occ_nxt        = occ_r;
    pend_nxt       = pend_r;
    pend_id_nxt    = pend_id_r;
    ncol_nxt       = ncol_r;
    strobe_nxt     = 1'b0;
    kind_nxt       = KIND_ACK;
    listed_nxt     = '0;
    ev_nxt         = 1'b0;
    ev_id_nxt      = '0;
    last_nxt       = 1'b0;
    tail_cmd       = CELL_CMD_KEEP;
    shift_en       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        idx_nxt = '0;
        if (start) begin
          if (in_command == CMD_LIST) begin
            pend_nxt  = 1'b0;
            ncol_nxt  = '0;
            state_nxt = S_LIST;
          end else if ({1'b0, CW'(in_candidate_id)} >= ID_LIMIT) begin
            strobe_nxt = 1'b1;
            last_nxt   = 1'b1;
          end else begin
            if (seq_r != SEQ_MAX) begin
              seq_nxt = seq_r + 1'b1;
            end
            id_nxt    = in_candidate_id;
            hit_nxt   = 1'b0;
            found_nxt = 1'b0;
            state_nxt = S_SCAN;
          end
        end
      end

      // first lap: bump a resident id, track the eviction victim
      S_SCAN: begin
        shift_en = 1'b1;
        idx_nxt  = lap_end ? '0 : idx_r + 1'b1;
        if (at_id && head.res) begin
          hit_nxt     = 1'b1;
          tail_cmd.op = OP_BUMP;
        end else if (head.res && better) begin
          found_nxt      = 1'b1;
          best_id_nxt    = idx_r;
          best_cnt_nxt   = head.cnt;
          best_stamp_nxt = head.stamp;
        end
        if (lap_end) begin
          if (hit_r || (at_id && head.res)) begin
            strobe_nxt = 1'b1;
            last_nxt   = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            state_nxt = S_PLACE;
          end
        end
      end

      // second lap: clear the victim if the slots are full, insert the new id
      S_PLACE: begin
        shift_en = 1'b1;
        idx_nxt  = lap_end ? '0 : idx_r + 1'b1;
        if (at_id) begin
          tail_cmd.op    = OP_INSERT;
          tail_cmd.stamp = seq_r;
        end else if (evict && at_best) begin
          tail_cmd.op = OP_CLEAR;
        end
        if (lap_end) begin
          if (!evict && occ_r != OCC_MAX) begin
            occ_nxt = occ_r + 1'b1;
          end
          strobe_nxt = 1'b1;
          ev_nxt     = evict;
          ev_id_nxt  = evict ? IdW'(best_id_r) : '0;
          last_nxt   = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      // one entry is held back so the final beat can carry last
      S_LIST: begin
        shift_en = 1'b1;
        idx_nxt  = lap_end ? '0 : idx_r + 1'b1;
        if (head.res && ncol_r < NCOL_CAP) begin
          if (pend_r) begin
            strobe_nxt = 1'b1;
            kind_nxt   = KIND_ENTRY;
            listed_nxt = IdW'(pend_id_r);
          end
          pend_nxt    = 1'b1;
          pend_id_nxt = idx_r;
          ncol_nxt    = ncol_r + 1'b1;
        end
        if (lap_end) begin
          state_nxt = S_FLUSH;
        end
      end

      S_FLUSH: begin
        strobe_nxt = 1'b1;
        last_nxt   = 1'b1;
        if (pend_r) begin
          kind_nxt   = KIND_ENTRY;
          listed_nxt = IdW'(pend_id_r);
        end else begin
          kind_nxt = KIND_EMPTY;
        end
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      idx_r    <= '0;
      seq_r    <= '0;
      occ_r    <= '0;
      slots_r  <= SlotW'(SlotsReset);
      strobe_r <= 1'b0;
      hit_r    <= 1'b0;
      found_r  <= 1'b0;
      pend_r   <= 1'b0;
      ncol_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      seq_r    <= seq_nxt;
      occ_r    <= occ_nxt;
      strobe_r <= strobe_nxt;
      hit_r    <= hit_nxt;
      found_r  <= found_nxt;
      pend_r   <= pend_nxt;
      ncol_r   <= ncol_nxt;
      if (cfg_valid && cfg_ready) begin
        slots_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    id_r         <= id_nxt;
    best_id_r    <= best_id_nxt;
    best_cnt_r   <= best_cnt_nxt;
    best_stamp_r <= best_stamp_nxt;
    pend_id_r    <= pend_id_nxt;
    kind_r       <= kind_nxt;
    listed_r     <= listed_nxt;
    ev_r         <= ev_nxt;
    ev_id_r      <= ev_id_nxt;
    last_r       <= last_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign cfg_ready      = 1'b1;
  assign out_strobe     = strobe_r;
  assign out_kind       = kind_r;
  assign out_listed_id  = listed_r;
  assign out_evicted    = ev_r;
  assign out_evicted_id = ev_id_r;
  assign out_last       = last_r;

  // the ring is back in id order whenever no item is in flight
  a_ring_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (idx_r == '0))
    else $error("ring not aligned while idle");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last) |-> !busy)
    else $error("final beat while still busy");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_kind == KIND_EMPTY) |-> out_last)
    else $error("empty list beat not marked last");

  a_no_evict_on_list: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_kind != KIND_ACK) |-> !out_evicted)
    else $error("eviction reported on a list beat");

endmodule

// ===== src/lfusr_cell.sv =====
// ----------------------------------------------------------------------------
// lfusr_cell
// One ring cell: holds the entry of one id and takes its neighbor's entry,
// applying an update on the way in.
// ----------------------------------------------------------------------------
module lfusr_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                shift_en,
  input  lfusr_pkg::entry_t   d,
  input  lfusr_pkg::cell_cmd_t cmd,
  output lfusr_pkg::entry_t   q
);
  import lfusr_pkg::*;

  entry_t q_r;
  entry_t q_nxt;
  logic [CountW-1:0] cnt_inc;

  assign cnt_inc = (d.cnt == COUNT_MAX) ? d.cnt : d.cnt + 1'b1;

  always_comb begin
    q_nxt = d;
    unique case (cmd.op)
      OP_KEEP: begin
      end
      OP_BUMP: begin
        q_nxt.cnt = cnt_inc;
      end
      OP_CLEAR: begin
        q_nxt.res = 1'b0;
        q_nxt.cnt = '0;
      end
      OP_INSERT: begin
        q_nxt.res   = 1'b1;
        q_nxt.cnt   = cnt_inc;
        q_nxt.stamp = cmd.stamp;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.res <= 1'b0;
      q_r.cnt <= '0;
    end else if (shift_en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

// ===== bench/lfu_slot_replacement_unit_test.sv =====
// ----------------------------------------------------------------------------
// lfu_slot_replacement_unit_test
// Self-checking bench for the lfu slot replacement unit: recommend and list
// commands are sent in random bursts, and every result is compared with a
// behavioral lfu cache kept inside the bench, across several slot limits.
// ----------------------------------------------------------------------------
module lfu_slot_replacement_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lfusr_pkg::*;

  localparam int unsigned NumIds    = 128;
  localparam int unsigned SlotLimit = 32;
  localparam int unsigned CycleCap  = 2000000;

  typedef struct {
    cmd_t       cmd;
    logic [6:0] id;
  } request_t;

  typedef struct {
    kind_t      kind;
    logic [6:0] listed_id;
    logic       evicted;
    logic [6:0] evicted_id;
    logic       last;
  } reply_t;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic       in_command;
  logic [6:0] in_candidate_id;
  logic       out_strobe;
  logic [1:0] out_kind;
  logic [6:0] out_listed_id;
  logic       out_evicted;
  logic [6:0] out_evicted_id;
  logic       out_last;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [5:0] cfg_data;

  lfu_slot_replacement_unit u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_candidate_id(in_candidate_id),
    .out_strobe(out_strobe), .out_kind(out_kind), .out_listed_id(out_listed_id),
    .out_evicted(out_evicted), .out_evicted_id(out_evicted_id),
    .out_last(out_last), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  // cache model state
  logic [SlotW-1:0]  slots_cfg;
  logic              resident[NumIds];
  logic [CountW-1:0] hits[NumIds];
  logic [StampW-1:0] stamps[NumIds];
  logic [SlotW-1:0]  occupancy;
  logic [StampW-1:0] seq_no;

  request_t pending_reqs[$];
  reply_t   expected_replies[$];
  request_t on_port;
  int       errors;
  int       accepted_reqs;
  int       checked_replies;
  int       evictions_seen;
  int       cycles;
  int       burst_left;
  int       gap_left;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void cache_reset();
    slots_cfg = SlotW'(SlotsReset);
    for (int i = 0; i < NumIds; i++) begin
      resident[i] = 1'b0;
      hits[i]     = '0;
      stamps[i]   = '0;
    end
    occupancy = '0;
    seq_no    = '0;
  endfunction

  function automatic void cache_apply(request_t req);
    reply_t r;
    int     n;
    int     limit;
    int     best;
    r = '{kind: KIND_ACK, listed_id: '0, evicted: 1'b0, evicted_id: '0, last: 1'b1};
    if (req.cmd == CMD_LIST) begin
      n = 0;
      for (int i = 0; i < NumIds && n < ResultCap; i++) begin
        if (resident[i]) begin
          if (n > 0) expected_replies.push_back(r);
          r = '{kind: KIND_ENTRY, listed_id: 7'(i), evicted: 1'b0,
                evicted_id: '0, last: 1'b0};
          n++;
        end
      end
      if (n == 0) r.kind = KIND_EMPTY;
      r.last = 1'b1;
      expected_replies.push_back(r);
      return;
    end
    if (seq_no != SEQ_MAX) seq_no++;
    if (resident[req.id]) begin
      if (hits[req.id] != COUNT_MAX) hits[req.id]++;
    end else begin
      limit = (slots_cfg == 0) ? 1 : (slots_cfg > SlotLimit) ? SlotLimit : slots_cfg;
      if (occupancy >= limit) begin
        best = -1;
        // lowest count, then oldest stamp, then lowest id
        for (int j = 0; j < NumIds; j++) begin
          if (resident[j] && (best < 0 || hits[j] < hits[best] ||
              (hits[j] == hits[best] && stamps[j] < stamps[best]))) best = j;
        end
        if (best >= 0) begin
          resident[best] = 1'b0;
          hits[best]     = '0;
          r.evicted      = 1'b1;
          r.evicted_id   = 7'(best);
        end else if (occupancy != OCC_MAX) begin
          occupancy++;
        end
      end else begin
        occupancy++;
      end
      resident[req.id] = 1'b1;
      if (hits[req.id] != COUNT_MAX) hits[req.id]++;
      stamps[req.id] = seq_no;
    end
    expected_replies.push_back(r);
  endfunction

  // driver: bursts with random gaps
  always @(posedge clk) begin
    logic     next_start;
    request_t nxt;
    if (!rst_n) begin
      start           <= 1'b0;
      in_command      <= 1'b0;
      in_candidate_id <= '0;
      burst_left      <= 0;
      gap_left        <= 0;
    end else if (!start || !busy) begin
      if (start) begin
        cache_apply(on_port);
        accepted_reqs++;
      end
      next_start = 1'b0;
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_reqs.size() > 0) begin
        nxt = pending_reqs.pop_front();
        on_port         <= nxt;
        in_command      <= nxt.cmd;
        in_candidate_id <= nxt.id;
        next_start = 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
      start <= next_start;
    end
  end

  // monitor: every strobed beat against the oldest expectation
  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_strobe) begin
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected beat kind=%0d listed=%0d ev=%0d ev_id=%0d last=%0d",
                 $time, out_kind, out_listed_id, out_evicted, out_evicted_id, out_last);
        errors++;
      end else begin
        want = expected_replies.pop_front();
        checked_replies++;
        if (want.evicted) evictions_seen++;
        if (out_kind !== want.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, want.kind, out_kind);
          errors++;
        end
        if (out_listed_id !== want.listed_id) begin
          $display("%0t: listed_id expected %0d actual %0d",
                   $time, want.listed_id, out_listed_id);
          errors++;
        end
        if (out_evicted !== want.evicted) begin
          $display("%0t: evicted expected %0d actual %0d", $time, want.evicted, out_evicted);
          errors++;
        end
        if (out_evicted_id !== want.evicted_id) begin
          $display("%0t: evicted_id expected %0d actual %0d",
                   $time, want.evicted_id, out_evicted_id);
          errors++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last expected %0d actual %0d", $time, want.last, out_last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleCap) begin
      $display("timeout after %0d cycles, %0d beats outstanding",
               cycles, expected_replies.size());
      $display("lfu_slot_replacement_unit_test: FAIL");
      $finish;
    end
  end

  task automatic push_req(cmd_t cmd, logic [6:0] id);
    request_t req;
    req.cmd = cmd;
    req.id  = id;
    pending_reqs.push_back(req);
  endtask

  task automatic drain();
    do @(posedge clk); while (pending_reqs.size() > 0 || start ||
                              expected_replies.size() > 0 || busy);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_slots(logic [5:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    slots_cfg = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic random_reqs(int count, int pool);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 7) == 0) push_req(CMD_LIST, 7'($urandom));
      else if ($urandom_range(0, 4) == 0) push_req(CMD_RECOMMEND, 7'($urandom_range(0, 127)));
      else push_req(CMD_RECOMMEND, 7'($urandom_range(0, pool)));
    end
  endtask

  initial begin
    errors = 0;
    accepted_reqs = 0;
    checked_replies = 0;
    evictions_seen = 0;
    cycles = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_command = 1'b0;
    in_candidate_id = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    cache_reset();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty list, id extremes, hits, list, then two-slot and one-slot limits
    push_req(CMD_LIST, 7'h7f);
    push_req(CMD_RECOMMEND, 7'd0);
    push_req(CMD_RECOMMEND, 7'd127);
    push_req(CMD_RECOMMEND, 7'd0);
    push_req(CMD_RECOMMEND, 7'd85);
    push_req(CMD_RECOMMEND, 7'd42);
    push_req(CMD_LIST, 7'd0);
    drain();
    write_slots(6'd2);
    // limit lowered below occupancy, then count and age tiebreaks
    push_req(CMD_RECOMMEND, 7'd10);
    push_req(CMD_RECOMMEND, 7'd11);
    push_req(CMD_RECOMMEND, 7'd11);
    push_req(CMD_RECOMMEND, 7'd12);
    push_req(CMD_LIST, 7'd0);
    drain();
    write_slots(6'd0);
    push_req(CMD_RECOMMEND, 7'd127);
    push_req(CMD_RECOMMEND, 7'd1);
    push_req(CMD_LIST, 7'd0);
    drain();
    write_slots(6'd63);
    for (int i = 0; i < 34; i++) push_req(CMD_RECOMMEND, 7'(i * 3 + 20));
    push_req(CMD_LIST, 7'd0);
    drain();

    // random phases over several limits
    write_slots(6'd32);
    random_reqs(40, 63);
    drain();
    write_slots(6'd4);
    random_reqs(40, 12);
    drain();
    write_slots(6'd1);
    random_reqs(25, 6);
    drain();
    write_slots(6'($urandom_range(5, 31)));
    random_reqs(50, 40);
    drain();

    $display("covered %0d commands and %0d result beats, %0d with an eviction",
             accepted_reqs, checked_replies, evictions_seen);
    $display("slot limits 0, 1, 2, 4, 20, 32, 63 and one random value");
    if (errors == 0 && expected_replies.size() == 0) begin
      $display("lfu_slot_replacement_unit_test: PASS");
    end else begin
      $display("lfu_slot_replacement_unit_test: FAIL");
    end
    $finish;
  end

endmodule
